>>> design/priority_ready_queue_scheduler_macros.svh
// Assertion macros shared by the scheduler checker.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/prq_pkg.sv
// Shared types and constants of the priority ready-queue scheduler.
// Used by the controller, the top level, the checker and the testbench; depends on nothing.
`default_nettype none

package prq_pkg;

    localparam int ID_W            = 6;
    localparam int PRIO_W          = 8;
    localparam int LVL_OUT_W       = 4;
    localparam int DEF_NUM_LEVELS  = 16;
    localparam int DEF_MAX_THREADS = 64;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_YIELD   = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP,
        S_PICK,
        S_POP,
        S_LINK,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

>>> design/prq_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Holds the level head/tail table and the thread link table; no package dependency.
`default_nettype none

module prq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/prq_ctrl.sv
// Sequencer of the scheduler: non-empty bits, running thread, result register,
// and the read-modify-write steps on the level and link RAMs. Uses prq_pkg.
`default_nettype none

module prq_ctrl #(
    parameter int NUM_LEVELS  = prq_pkg::DEF_NUM_LEVELS,
    parameter int MAX_THREADS = prq_pkg::DEF_MAX_THREADS,
    parameter int LW          = $clog2(NUM_LEVELS),
    parameter int TW          = $clog2(MAX_THREADS)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_action,
    input  wire logic [prq_pkg::ID_W-1:0]     i_thread_id,
    input  wire logic [prq_pkg::PRIO_W-1:0]   i_priority_req,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_running_valid,
    output logic [prq_pkg::ID_W-1:0]          o_running_thread,
    output logic [prq_pkg::LVL_OUT_W-1:0]     o_running_priority,
    output logic                              o_all_queues_empty,
    // level RAM: {head, tail} per level
    output logic                              o_lvl_we,
    output logic [LW-1:0]                     o_lvl_waddr,
    output logic [2*prq_pkg::ID_W-1:0]        o_lvl_wdata,
    output logic [LW-1:0]                     o_lvl_raddr,
    input  wire logic [2*prq_pkg::ID_W-1:0]   i_lvl_rdata,
    // link RAM: next thread per thread
    output logic                              o_link_we,
    output logic [TW-1:0]                     o_link_waddr,
    output logic [prq_pkg::ID_W-1:0]          o_link_wdata,
    output logic [TW-1:0]                     o_link_raddr,
    input  wire logic [prq_pkg::ID_W-1:0]     i_link_rdata
);

    import prq_pkg::*;

    t_state                r_state, n_state;
    logic [NUM_LEVELS-1:0] r_nonempty, n_nonempty;
    logic                  r_run_flag, n_run_flag;
    logic [ID_W-1:0]       r_run_id, n_run_id;
    logic [LW-1:0]         r_run_lvl, n_run_lvl;
    t_action               r_act, n_act;
    logic [ID_W-1:0]       r_id, n_id;
    logic [LW-1:0]         r_lvl, n_lvl;
    logic [ID_W-1:0]       r_tail, n_tail;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_flag;
    logic [ID_W-1:0]       r_out_id;
    logic [LW-1:0]         r_out_lvl;
    logic                  r_out_empty;
    logic                  n_out_load, n_out_empty;

    logic [LW-1:0]         in_lvl;
    logic                  id_ok;
    logic [LW-1:0]         pick_lvl;
    logic                  pick_found;
    logic [ID_W-1:0]       lvl_head, lvl_tail;
    logic                  out_free;

    assign lvl_head = i_lvl_rdata[2*ID_W-1:ID_W];
    assign lvl_tail = i_lvl_rdata[ID_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (int'(i_priority_req) >= NUM_LEVELS) begin
            in_lvl = LW'(NUM_LEVELS - 1);
        end else begin
            in_lvl = LW'(i_priority_req);
        end
        id_ok = int'(i_thread_id) < MAX_THREADS;
    end

    // Highest non-empty level; later iterations override earlier ones.
    always_comb begin
        pick_lvl   = '0;
        pick_found = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (r_nonempty[i]) begin
                pick_lvl   = LW'(i);
                pick_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nonempty  <= '0;
            r_run_flag  <= 1'b0;
            r_run_id    <= '0;
            r_run_lvl   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_run_flag  <= n_run_flag;
            r_run_id    <= n_run_id;
            r_run_lvl   <= n_run_lvl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_id   <= n_id;
        r_lvl  <= n_lvl;
        r_tail <= n_tail;
        if (n_out_load) begin
            r_out_flag  <= r_run_flag;
            r_out_id    <= r_run_id;
            r_out_lvl   <= r_run_lvl;
            r_out_empty <= n_out_empty;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_nonempty  = r_nonempty;
        n_run_flag  = r_run_flag;
        n_run_id    = r_run_id;
        n_run_lvl   = r_run_lvl;
        n_act       = r_act;
        n_id        = r_id;
        n_lvl       = r_lvl;
        n_tail      = r_tail;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_load  = 1'b0;
        n_out_empty = ~|r_nonempty;

        o_lvl_we     = 1'b0;
        o_lvl_waddr  = r_lvl;
        o_lvl_wdata  = {lvl_head, r_id};
        o_lvl_raddr  = r_lvl;
        o_link_we    = 1'b0;
        o_link_waddr = TW'(lvl_tail);
        o_link_wdata = r_id;
        o_link_raddr = TW'(lvl_head);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act = t_action'(i_action);
                    if (t_action'(i_action) == ACT_ENQUEUE) begin
                        n_id        = i_thread_id;
                        n_lvl       = in_lvl;
                        o_lvl_raddr = in_lvl;
                        n_state     = id_ok ? S_APP : S_RESULT;
                    end else begin
                        // A yield first puts the running thread back at its level.
                        n_id        = r_run_id;
                        n_lvl       = r_run_lvl;
                        o_lvl_raddr = r_run_lvl;
                        n_state     = r_run_flag ? S_APP : S_PICK;
                    end
                end
            end
            S_APP: begin
                o_lvl_we = 1'b1;
                if (r_nonempty[r_lvl]) begin
                    o_link_we   = 1'b1;
                    o_lvl_wdata = {lvl_head, r_id};
                end else begin
                    o_lvl_wdata = {r_id, r_id};
                end
                n_nonempty[r_lvl] = 1'b1;
                if (r_act == ACT_YIELD) begin
                    n_state = S_PICK;
                end else if (out_free) begin
                    // The level just appended to is non-empty, so the queues are too.
                    n_out_load  = 1'b1;
                    n_out_empty = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_PICK: begin
                if (!pick_found) begin
                    n_run_flag = 1'b0;
                    n_run_id   = '0;
                    n_run_lvl  = '0;
                    n_state    = S_RESULT;
                end else begin
                    n_lvl       = pick_lvl;
                    o_lvl_raddr = pick_lvl;
                    n_state     = S_POP;
                end
            end
            S_POP: begin
                n_run_flag = 1'b1;
                n_run_id   = lvl_head;
                n_run_lvl  = r_lvl;
                if (lvl_head == lvl_tail) begin
                    n_nonempty[r_lvl] = 1'b0;
                    n_state           = S_RESULT;
                end else begin
                    n_tail  = lvl_tail;
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                o_lvl_we    = 1'b1;
                o_lvl_wdata = {i_link_rdata, r_tail};
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_running_valid    = r_out_flag;
    assign o_running_thread   = r_out_id;
    assign o_running_priority = LVL_OUT_W'(r_out_lvl);
    assign o_all_queues_empty = r_out_empty;

endmodule

`default_nettype wire

>>> design/priority_ready_queue_scheduler.sv
// Priority ready-queue scheduler. Each of NUM_LEVELS levels is a FIFO of thread ids
// kept as a linked list: a level RAM holds head and tail per level, a link RAM holds
// the next id per thread, and a register holds one non-empty bit per level. An
// enqueue word appends its thread at its level and then loads its result; a yield
// re-appends the running thread if any, picks the highest non-empty level, reads
// its head and, where that level holds more than one thread, its link (re-append,
// pick, head read, link read), each step waiting on the registered read data of the
// two RAMs. A result that cannot leave the output register adds its stall.
// One word is worked on at a time; the result sits in an output register, so a
// new word is accepted while the previous result waits. No clearing pass follows
// reset: entries are read only where a non-empty bit says they were written.
// Depends on prq_pkg, prq_ctrl and prq_ram.
`default_nettype none

module priority_ready_queue_scheduler #(
    parameter int NUM_LEVELS  = prq_pkg::DEF_NUM_LEVELS,
    parameter int MAX_THREADS = prq_pkg::DEF_MAX_THREADS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_action,
    input  wire logic [prq_pkg::ID_W-1:0]     i_thread_id,
    input  wire logic [prq_pkg::PRIO_W-1:0]   i_priority_req,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_running_valid,
    output logic [prq_pkg::ID_W-1:0]          o_running_thread,
    output logic [prq_pkg::LVL_OUT_W-1:0]     o_running_priority,
    output logic                              o_all_queues_empty
);

    import prq_pkg::*;

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int TW = $clog2(MAX_THREADS);

    logic                lvl_we;
    logic [LW-1:0]       lvl_waddr, lvl_raddr;
    logic [2*ID_W-1:0]   lvl_wdata, lvl_rdata;
    logic                link_we;
    logic [TW-1:0]       link_waddr, link_raddr;
    logic [ID_W-1:0]     link_wdata, link_rdata;

    prq_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_thread_id        (i_thread_id),
        .i_priority_req     (i_priority_req),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_running_valid    (o_running_valid),
        .o_running_thread   (o_running_thread),
        .o_running_priority (o_running_priority),
        .o_all_queues_empty (o_all_queues_empty),
        .o_lvl_we           (lvl_we),
        .o_lvl_waddr        (lvl_waddr),
        .o_lvl_wdata        (lvl_wdata),
        .o_lvl_raddr        (lvl_raddr),
        .i_lvl_rdata        (lvl_rdata),
        .o_link_we          (link_we),
        .o_link_waddr       (link_waddr),
        .o_link_wdata       (link_wdata),
        .o_link_raddr       (link_raddr),
        .i_link_rdata       (link_rdata)
    );

    prq_ram #(
        .DEPTH (NUM_LEVELS),
        .WIDTH (2 * ID_W)
    ) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    prq_ram #(
        .DEPTH (MAX_THREADS),
        .WIDTH (ID_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

endmodule

`default_nettype wire

>>> design/prq_checker.sv
// Port-level checker for the scheduler, bound to the top level below.
// Depends on prq_pkg and the assertion macros header.
`default_nettype none
`include "priority_ready_queue_scheduler_macros.svh"

module prq_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic                         o_running_valid,
    input wire logic [prq_pkg::ID_W-1:0]     o_running_thread,
    input wire logic [prq_pkg::LVL_OUT_W-1:0] o_running_priority,
    input wire logic                         o_all_queues_empty
);

    logic [prq_pkg::ID_W+prq_pkg::LVL_OUT_W+1:0] res_word;
    logic                                        out_stall;
    logic                                        in_take;
    logic                                        idle_zero;

    assign res_word  = {o_running_valid, o_running_thread, o_running_priority,
                        o_all_queues_empty};
    assign out_stall = o_out_valid && !i_out_ready;
    assign in_take   = i_in_valid && o_in_ready;
    assign idle_zero = (o_running_thread == '0) && (o_running_priority == '0);

    // A stalled result word keeps its value.
    `PRQ_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(res_word), "stalled result changed")

    // With nothing running, the thread and level fields read as zero.
    `PRQ_ASSERT_NOW(a_idle_fields, o_out_valid && !o_running_valid, idle_zero, "idle result not zero")

    // Words are worked on one at a time, so ready drops after an accept.
    `PRQ_ASSERT_NEXT(a_one_at_a_time, in_take, !o_in_ready, "input accepted while busy")

    // No result word appears straight out of reset.
    `PRQ_ASSERT_NOW(a_reset_quiet, !$past(i_rst_n), !o_out_valid, "result valid after reset")

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (.*);

`default_nettype wire

>>> tb/tb_priority_ready_queue_scheduler.sv
// Testbench for the priority ready-queue scheduler: directed rows, then random enqueue/yield
// traffic, with each result word checked against a behavioral predictor of the ready queues or a typed expectation.
// Depends on prq_pkg and priority_ready_queue_scheduler.
module tb_priority_ready_queue_scheduler;
    import prq_pkg::*;

    localparam int LEVELS   = DEF_NUM_LEVELS;
    localparam int THREADS  = DEF_MAX_THREADS;
    localparam int TOP_LVL  = LEVELS - 1;
    localparam int N_RANDOM = 600;
    localparam int N_DIR    = 24;

    typedef struct packed {
        logic                 valid;
        logic [ID_W-1:0]      thread;
        logic [LVL_OUT_W-1:0] prio;
        logic                 empty;
    } t_run_word;

    typedef struct packed {
        t_action         act;
        logic [ID_W-1:0] id;
        logic [PRIO_W-1:0] pr;
        logic            typed;
        t_run_word       want;
    } t_dir_row;

    // Typed expectations only where the result is obvious right after reset.
    localparam t_dir_row DIR_ROWS [0:N_DIR-1] = '{
        '{ACT_YIELD,   6'd0,  8'd0,   1'b1, '{1'b0, 6'd0,  4'd0,  1'b1}},
        '{ACT_ENQUEUE, 6'd63, 8'd255, 1'b1, '{1'b0, 6'd0,  4'd0,  1'b0}},
        '{ACT_YIELD,   6'd63, 8'd255, 1'b1, '{1'b1, 6'd63, 4'd15, 1'b1}},
        '{ACT_YIELD,   6'd0,  8'd0,   1'b1, '{1'b1, 6'd63, 4'd15, 1'b1}},
        '{ACT_ENQUEUE, 6'd0,  8'd0,   1'b1, '{1'b1, 6'd63, 4'd15, 1'b0}},
        '{ACT_ENQUEUE, 6'd21, 8'd16,  1'b1, '{1'b1, 6'd63, 4'd15, 1'b0}},
        '{ACT_ENQUEUE, 6'd42, 8'd128, 1'b0, '0},
        '{ACT_ENQUEUE, 6'd10, 8'd15,  1'b0, '0},
        '{ACT_ENQUEUE, 6'd11, 8'd7,   1'b0, '0},
        '{ACT_YIELD,   6'd21, 8'd85,  1'b0, '0},
        '{ACT_ENQUEUE, 6'd42, 8'd3,   1'b0, '0},
        '{ACT_ENQUEUE, 6'd5,  8'd1,   1'b0, '0},
        '{ACT_YIELD,   6'd42, 8'd170, 1'b0, '0},
        '{ACT_ENQUEUE, 6'd21, 8'd15,  1'b0, '0},
        '{ACT_YIELD,   6'd63, 8'd0,   1'b0, '0},
        '{ACT_YIELD,   6'd0,  8'd255, 1'b0, '0},
        '{ACT_YIELD,   6'd31, 8'd64,  1'b0, '0},
        '{ACT_YIELD,   6'd32, 8'd32,  1'b0, '0},
        '{ACT_YIELD,   6'd16, 8'd8,   1'b0, '0},
        '{ACT_YIELD,   6'd8,  8'd4,   1'b0, '0},
        '{ACT_YIELD,   6'd4,  8'd2,   1'b0, '0},
        '{ACT_YIELD,   6'd2,  8'd1,   1'b0, '0},
        '{ACT_ENQUEUE, 6'd32, 8'd14,  1'b0, '0},
        '{ACT_YIELD,   6'd1,  8'd127, 1'b0, '0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_action;
    logic [ID_W-1:0]   i_thread_id;
    logic [PRIO_W-1:0] i_priority_req;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_running_valid;
    logic [ID_W-1:0]   o_running_thread;
    logic [LVL_OUT_W-1:0] o_running_priority;
    logic              o_all_queues_empty;

    priority_ready_queue_scheduler dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_thread_id        (i_thread_id),
        .i_priority_req     (i_priority_req),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_running_valid    (o_running_valid),
        .o_running_thread   (o_running_thread),
        .o_running_priority (o_running_priority),
        .o_all_queues_empty (o_all_queues_empty)
    );

    // Predicted ready-queue state.
    logic [ID_W-1:0]      lvl_head [LEVELS];
    logic [ID_W-1:0]      lvl_tail [LEVELS];
    logic [LEVELS-1:0]    lvl_busy;
    logic [ID_W-1:0]      link_next [THREADS];
    bit                   link_set [THREADS];
    logic [ID_W-1:0]      run_id;
    logic                 run_flag;
    logic [LVL_OUT_W-1:0] run_lvl;

    t_run_word expected_runs [$];
    int        mismatch_count;
    int        words_taken;
    int        words_checked;
    bit        drv_typed;
    t_run_word drv_typed_word;
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        placed [THREADS];
    int        n_placed;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] mismatch at word %0d: %s", $time, words_checked, what);
        end
    endtask

    function automatic void ready_append(input logic [ID_W-1:0] id,
                                         input logic [LVL_OUT_W-1:0] lvl);
        if (lvl_busy[lvl]) begin
            link_next[lvl_tail[lvl]] = id;
            link_set[lvl_tail[lvl]]  = 1'b1;
            lvl_tail[lvl]            = id;
        end else begin
            lvl_head[lvl] = id;
            lvl_tail[lvl] = id;
            lvl_busy[lvl] = 1'b1;
        end
    endfunction

    function automatic t_run_word sched_apply(input t_action act, input logic [ID_W-1:0] id,
                                              input logic [PRIO_W-1:0] pr);
        t_run_word       w;
        logic [ID_W-1:0] h;
        bit              found;
        int              p;
        if (act == ACT_ENQUEUE) begin
            ready_append(id, (pr > TOP_LVL) ? LVL_OUT_W'(TOP_LVL) : pr[LVL_OUT_W-1:0]);
        end else begin
            if (run_flag) begin
                ready_append(run_id, run_lvl);
            end
            run_flag = 1'b0;
            run_id   = '0;
            run_lvl  = '0;
            found    = 1'b0;
            for (p = TOP_LVL; p >= 0; p--) begin
                if (!found && lvl_busy[p]) begin
                    h = lvl_head[p];
                    if (h == lvl_tail[p]) begin
                        lvl_busy[p] = 1'b0;
                    end else begin
                        lvl_head[p] = link_next[h];
                    end
                    run_flag = 1'b1;
                    run_id   = h;
                    run_lvl  = LVL_OUT_W'(p);
                    found    = 1'b1;
                end
            end
        end
        w.valid  = run_flag;
        w.thread = run_flag ? run_id : '0;
        w.prio   = run_flag ? run_lvl : '0;
        w.empty  = (lvl_busy == '0);
        return w;
    endfunction

    // A yield would follow a link that was never written when shared links leave a
    // level whose head was never anyone's tail there; such yields are sent as enqueues.
    function automatic bit yield_hits_blank();
        int              p;
        logic [ID_W-1:0] h;
        logic [ID_W-1:0] t;
        bit              own;
        bit              linked;
        for (p = TOP_LVL; p >= 0; p--) begin
            own = run_flag && (run_lvl == p);
            if (lvl_busy[p] || own) begin
                h = (own && !lvl_busy[p]) ? run_id : lvl_head[p];
                t = own ? run_id : lvl_tail[p];
                linked = link_set[h] || (own && lvl_busy[p] && lvl_tail[p] == h);
                return (h != t) && !linked;
            end
        end
        return 1'b0;
    endfunction

    task automatic offer_word(input t_action act, input logic [ID_W-1:0] id,
                              input logic [PRIO_W-1:0] pr, input bit typed,
                              input t_run_word typed_word);
        int target;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        if (act == ACT_YIELD && yield_hits_blank()) begin
            act = ACT_ENQUEUE;
        end
        if (act == ACT_ENQUEUE && !placed[id]) begin
            placed[id] = 1'b1;
            n_placed++;
        end
        drv_typed      = typed;
        drv_typed_word = typed_word;
        target         = words_taken + 1;
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_thread_id    <= id;
        i_priority_req <= pr;
        do @(negedge i_clk); while (words_taken != target);
    endtask

    always @(posedge i_clk) begin
        t_run_word got;
        t_run_word want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = sched_apply(t_action'(i_action), i_thread_id, i_priority_req);
                expected_runs.push_back(drv_typed ? drv_typed_word : want);
                words_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_running_valid, o_running_thread, o_running_priority,
                        o_all_queues_empty};
                if (expected_runs.size() == 0) begin
                    flag_mismatch("result word with nothing expected");
                end else begin
                    want = expected_runs.pop_front();
                    if (got.valid !== want.valid)
                        flag_mismatch($sformatf("running_valid %0b, want %0b",
                                                got.valid, want.valid));
                    if (got.thread !== want.thread)
                        flag_mismatch($sformatf("running_thread %0d, want %0d",
                                                got.thread, want.thread));
                    if (got.prio !== want.prio)
                        flag_mismatch($sformatf("running_priority %0d, want %0d",
                                                got.prio, want.prio));
                    if (got.empty !== want.empty)
                        flag_mismatch($sformatf("all_queues_empty %0b, want %0b",
                                                got.empty, want.empty));
                end
                words_checked++;
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off that fills the block.
    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle    = 0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n) begin
                rx_cycle++;
                if (rx_cycle == 300) hold_left = 200;
                if (hold_left > 0) begin
                    hold_left--;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("** priority_ready_queue_scheduler: FAILED **");
        $finish;
    end

    initial begin
        int                i;
        t_action           act;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] pr;
        int                yield_pct;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = ACT_ENQUEUE;
        i_thread_id    = '0;
        i_priority_req = '0;
        lvl_busy       = '0;
        run_id         = '0;
        run_flag       = 1'b0;
        run_lvl        = '0;
        mismatch_count = 0;
        words_taken    = 0;
        words_checked  = 0;
        n_placed       = 0;
        drv_typed      = 1'b0;
        drv_typed_word = '0;
        tx_idle_pct    = 12;
        rx_idle_pct    = 48;
        for (i = 0; i < THREADS; i++) begin
            link_set[i] = 1'b0;
            placed[i]   = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < N_DIR; i++) begin
            offer_word(DIR_ROWS[i].act, DIR_ROWS[i].id, DIR_ROWS[i].pr,
                       DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        for (i = 0; i < N_RANDOM; i++) begin
            if (i < N_RANDOM / 3) begin
                tx_idle_pct = 12;
                rx_idle_pct = 48;
            end else if (i < 2 * N_RANDOM / 3) begin
                tx_idle_pct = 48;
                rx_idle_pct = 12;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Fill the levels with fresh threads first, then mostly rotate them.
            yield_pct = (n_placed == THREADS) ? 75 : 40;
            id = ID_W'($urandom);
            pr = PRIO_W'($urandom);
            if ($urandom_range(99) < yield_pct) begin
                act = ACT_YIELD;
            end else begin
                act = ACT_ENQUEUE;
                if (n_placed < THREADS && $urandom_range(99) < 85) begin
                    while (placed[id]) id = ID_W'($urandom);
                end
                pr = ($urandom_range(99) < 70) ? PRIO_W'($urandom_range(TOP_LVL))
                                               : PRIO_W'($urandom_range(LEVELS, 255));
            end
            offer_word(act, id, pr, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (expected_runs.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("** priority_ready_queue_scheduler: PASSED **");
        end else begin
            $display("** priority_ready_queue_scheduler: FAILED **");
        end
        $finish;
    end

endmodule
